FILE: sv/oale_pkg.sv
// Shared types, constants and helper functions of the ordered array list engine.
`timescale 1ns / 1ps

package oale_pkg;

   localparam int CAPACITY    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int MAX_RESULTS = 32;

   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int POS_BITS   = 5;
   localparam int MR_BITS    = $clog2(MAX_RESULTS + 1);
   localparam int KW_A       = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;
   localparam int KW         = (KW_A > MR_BITS) ? KW_A : MR_BITS;

   typedef enum logic [2:0] {
      ACT_CLEAR        = 3'd0,
      ACT_APPEND       = 3'd1,
      ACT_INSERT_AT    = 3'd2,
      ACT_DELETE_AT    = 3'd3,
      ACT_DELETE_VALUE = 3'd4,
      ACT_SEARCH       = 3'd5,
      ACT_DUMP         = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_INDEX = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_APPEND,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_DEL_RD,
      S_DEL_WR,
      S_FIND_RD,
      S_FIND_CMP,
      S_DUMP_RD,
      S_DUMP_EMIT,
      S_REPORT
   } seq_state_type;

   typedef struct packed {
      logic                  we;
      logic [IDX_BITS-1:0]   waddr;
      logic [VALUE_BITS-1:0] wdata;
      logic [IDX_BITS-1:0]   raddr;
   } mem_ctl_type;

   typedef struct packed {
      status_type         status;
      logic [4:0]         found_index;
      logic signed [31:0] entry_value;
      logic [5:0]         entry_count;
      logic               last;
   } rsp_data_type;

   // Sign-extend the 32-bit input value and keep its low VALUE_BITS bits.
   function automatic logic [VALUE_BITS-1:0] to_value(input logic signed [31:0] x);
      logic signed [63:0] w;
      w = 64'(x);
      return w[VALUE_BITS-1:0];
   endfunction

   // Sign-extend a stored entry and keep its low 32 bits.
   function automatic logic signed [31:0] to_entry(input logic [VALUE_BITS-1:0] x);
      logic signed [63:0] w;
      w = 64'(signed'(x));
      return w[31:0];
   endfunction

endpackage

FILE: sv/oale_if.sv
// Request and response channel interfaces of the ordered array list engine.
`timescale 1ns / 1ps

interface oale_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic signed [31:0] item_value;
   logic [4:0]         position;

   modport source (output valid, output action, output item_value, output position,
                   input ready);
   modport sink   (input valid, input action, input item_value, input position,
                   output ready);
endinterface

interface oale_rsp_if;
   logic                  valid;
   logic                  ready;
   oale_pkg::status_type  status;
   logic [4:0]            found_index;
   logic signed [31:0]    entry_value;
   logic [5:0]            entry_count;
   logic                  last;

   modport source (output valid, output status, output found_index, output entry_value,
                   output entry_count, output last, input ready);
   modport sink   (input valid, input status, input found_index, input entry_value,
                   input entry_count, input last, output ready);
endinterface

FILE: sv/oale_mem.sv
// Entry storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module oale_mem (
   input  logic                            clock,
   input  oale_pkg::mem_ctl_type           mem_ctl,
   output logic [oale_pkg::VALUE_BITS-1:0] rd_data
);
   import oale_pkg::*;

   logic [VALUE_BITS-1:0] mem_ff [CAPACITY];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.we) begin
         mem_ff[mem_ctl.waddr] <= mem_ctl.wdata;
      end
      rd_data_ff <= mem_ff[mem_ctl.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/oale_seq.sv
// Sequencer: walks the list one entry at a time for shift, compare and dump.
`timescale 1ns / 1ps

module oale_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_action,
   input  logic signed [31:0]              req_item_value,
   input  logic [4:0]                      req_position,
   output oale_pkg::mem_ctl_type           mem_ctl,
   input  logic [oale_pkg::VALUE_BITS-1:0] rd_data,
   input  logic                            out_free,
   output logic                            out_push,
   output oale_pkg::rsp_data_type          out_data
);
   import oale_pkg::*;

   seq_state_type         state_ff, state_in;
   action_type            act_ff, act_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [KW-1:0]         pos_ff, pos_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [KW-1:0]         idx_ff, idx_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   status_type            status_ff, status_in;

   logic [KW-1:0] count_ext;
   logic [KW-1:0] dump_end;
   logic          full;
   logic          match;

   assign count_ext = KW'(count_ff);
   assign dump_end  = (count_ext < KW'(MAX_RESULTS)) ? count_ext : KW'(MAX_RESULTS);
   assign full      = (count_ext >= KW'(CAPACITY));
   assign match     = (rd_data == value_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      act_ff    <= act_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      k_ff      <= k_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

   // Next state and datapath registers.
   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      value_in  = value_ff;
      pos_in    = pos_ff;
      k_in      = k_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = action_type'(req_action);
               value_in = to_value(req_item_value);
               pos_in   = KW'(req_position);
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            idx_in    = '0;
            k_in      = '0;
            state_in  = S_REPORT;
            case (act_ff)
               ACT_CLEAR: begin
                  count_in = '0;
               end
               ACT_APPEND: begin
                  if (full) status_in = ST_FULL;
                  else      state_in  = S_APPEND;
               end
               ACT_INSERT_AT: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else if (pos_ff > count_ext) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     k_in     = count_ext;
                     state_in = (count_ext == pos_ff) ? S_INS_PUT : S_INS_RD;
                  end
               end
               ACT_DELETE_AT: begin
                  if (pos_ff >= count_ext) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     k_in = pos_ff;
                     if (pos_ff + KW'(1) < count_ext) state_in = S_DEL_RD;
                     else                             count_in = count_ff - 1'b1;
                  end
               end
               ACT_DELETE_VALUE, ACT_SEARCH: begin
                  if (count_ff == '0) status_in = ST_NOT_FOUND;
                  else                state_in  = S_FIND_RD;
               end
               ACT_DUMP: begin
                  if (count_ff != '0) state_in = S_DUMP_RD;
               end
               default: begin
               end
            endcase
         end
         S_APPEND: begin
            count_in = count_ff + 1'b1;
            state_in = S_REPORT;
         end
         S_INS_RD: begin
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            k_in     = k_ff - KW'(1);
            state_in = (k_ff - KW'(1) == pos_ff) ? S_INS_PUT : S_INS_RD;
         end
         S_INS_PUT: begin
            count_in = count_ff + 1'b1;
            state_in = S_REPORT;
         end
         S_DEL_RD: begin
            state_in = S_DEL_WR;
         end
         S_DEL_WR: begin
            k_in = k_ff + KW'(1);
            if (k_ff + KW'(2) < count_ext) begin
               state_in = S_DEL_RD;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_REPORT;
            end
         end
         S_FIND_RD: begin
            state_in = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            if (match) begin
               if (act_ff == ACT_SEARCH) begin
                  idx_in   = k_ff;
                  state_in = S_REPORT;
               end else if (k_ff + KW'(1) < count_ext) begin
                  state_in = S_DEL_RD;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = S_REPORT;
               end
            end else if (k_ff + KW'(1) < count_ext) begin
               k_in     = k_ff + KW'(1);
               state_in = S_FIND_RD;
            end else begin
               status_in = ST_NOT_FOUND;
               state_in  = S_REPORT;
            end
         end
         S_DUMP_RD: begin
            state_in = S_DUMP_EMIT;
         end
         S_DUMP_EMIT: begin
            if (out_free) begin
               k_in     = k_ff + KW'(1);
               state_in = (k_ff + KW'(1) == dump_end) ? S_IDLE : S_DUMP_RD;
            end
         end
         S_REPORT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory control, handshake and result outputs.
   always_comb begin
      req_ready           = 1'b0;
      mem_ctl.we          = 1'b0;
      mem_ctl.waddr       = k_ff[IDX_BITS-1:0];
      mem_ctl.wdata       = rd_data;
      mem_ctl.raddr       = k_ff[IDX_BITS-1:0];
      out_push            = 1'b0;
      out_data.status      = status_ff;
      out_data.found_index = 5'(idx_ff);
      out_data.entry_value = '0;
      out_data.entry_count = 6'(count_ff);
      out_data.last        = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_APPEND: begin
            mem_ctl.we    = 1'b1;
            mem_ctl.waddr = count_ff[IDX_BITS-1:0];
            mem_ctl.wdata = value_ff;
         end
         S_INS_RD: begin
            mem_ctl.raddr = IDX_BITS'(k_ff - KW'(1));
         end
         S_INS_WR: begin
            mem_ctl.we = 1'b1;
         end
         S_INS_PUT: begin
            mem_ctl.we    = 1'b1;
            mem_ctl.waddr = pos_ff[IDX_BITS-1:0];
            mem_ctl.wdata = value_ff;
         end
         S_DEL_RD: begin
            mem_ctl.raddr = IDX_BITS'(k_ff + KW'(1));
         end
         S_DEL_WR: begin
            mem_ctl.we = 1'b1;
         end
         S_DUMP_EMIT: begin
            out_push             = out_free;
            out_data.status      = ST_OK;
            out_data.found_index = 5'(k_ff);
            out_data.entry_value = to_entry(rd_data);
            out_data.last        = (k_ff + KW'(1) == dump_end);
         end
         S_REPORT: begin
            out_push = out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: sv/ordered_array_list_engine.sv
// Ordered array list engine: a dense list of signed values edited by actions.
//
// Channels: req_chan takes one action item (action, item_value, position) when
// valid and ready are both high; rsp_chan gives result items with status,
// found_index, entry_value, entry_count and last. Each action gives one result,
// a dump gives one result per entry (up to 32), and the final one has last set.
// The sequencer walks the entry memory through its single read port one entry
// at a time. Clear, bad index and full go from decode straight to the report;
// append writes the value first. Insert moves each entry from the end down to
// the position up by one, then writes the value; delete at an index moves each
// later entry down by one. Search and delete by value compare the entries in
// order, and a delete by value then shifts as delete does. A dump reads and
// emits each entry in turn, waiting while the output is not free. Ready is high
// only while the sequencer is idle, so one action is worked on at a time.
// Reset empties the list (the count clears; entries are not cleared).
// A stalled receiver holds the result in the output register and the
// sequencer waits before giving the next one; nothing is dropped.
`timescale 1ns / 1ps

module ordered_array_list_engine (
   input  logic              clock,
   input  logic              reset,
   oale_req_if.sink          req_chan,
   oale_rsp_if.source        rsp_chan
);
   import oale_pkg::*;

   mem_ctl_type           mem_ctl;
   logic [VALUE_BITS-1:0] rd_data;
   logic                  out_free;
   logic                  out_push;
   rsp_data_type          out_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   oale_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_action     (req_chan.action),
      .req_item_value (req_chan.item_value),
      .req_position   (req_chan.position),
      .mem_ctl        (mem_ctl),
      .rd_data        (rd_data),
      .out_free       (out_free),
      .out_push       (out_push),
      .out_data       (out_data)
   );

   oale_mem u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Load a new item when pushed, drop the held one once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_data;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_data_ff.status;
   assign rsp_chan.found_index = rsp_data_ff.found_index;
   assign rsp_chan.entry_value = rsp_data_ff.entry_value;
   assign rsp_chan.entry_count = rsp_data_ff.entry_count;
   assign rsp_chan.last        = rsp_data_ff.last;

endmodule

FILE: bench/ordered_array_list_engine_tb.sv
// Self-checking testbench for the ordered array list engine with its own list predictor.
`timescale 1ns / 1ps

module ordered_array_list_engine_tb;
   import oale_pkg::*;

   localparam logic [2:0] ACT_UNUSED  = 3'd7;
   localparam int         QUIET_LIMIT = 2000;
   localparam int         RANDOM_CMDS = 85;
   localparam int         SHOW_LIMIT  = 40;

   typedef struct {
      logic [2:0]         act;
      logic signed [31:0] value;
      logic [4:0]         pos;
   } list_cmd_type;

   logic clock = 1'b0;
   logic reset;

   oale_req_if req_chan ();
   oale_rsp_if rsp_chan ();

   ordered_array_list_engine dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predicted list contents and length
   logic [VALUE_BITS-1:0] list_mem [CAPACITY];
   int                    list_len = 0;
   int                    peak_len = 0;

   list_cmd_type cmd_backlog [$];
   rsp_data_type awaited_rsp [$];
   list_cmd_type sent_cmd;

   int  req_gap     = 0;
   int  rsp_stall   = 0;
   bit  req_busy;
   bit  req_pending = 0;
   bit  no_idle     = 0;
   bit  grow        = 1;
   int  quiet       = 0;
   int  fail_count  = 0;
   int  rsp_checked = 0;
   int  act_count [8];
   int  status_seen [4];

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int locate_value(logic [VALUE_BITS-1:0] v);
      for (int k = 0; k < list_len; k++)
         if (list_mem[k] == v) return k;
      return -1;
   endfunction

   task automatic drop_entry(int p);
      for (int k = p; k + 1 < list_len; k++)
         list_mem[k] = list_mem[k + 1];
      list_len--;
   endtask

   // Update the list for one accepted action and queue the results it gives.
   task automatic apply_list_action(list_cmd_type c);
      rsp_data_type          r;
      logic [VALUE_BITS-1:0] v;
      int                    hit;
      v = VALUE_BITS'(c.value);
      r = '0;
      r.status = ST_OK;
      r.last   = 1'b1;
      act_count[c.act]++;
      case (c.act)
         ACT_CLEAR: list_len = 0;
         ACT_APPEND: begin
            if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               list_mem[list_len] = v;
               list_len++;
            end
         end
         ACT_INSERT_AT: begin
            if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (c.pos > list_len) begin
               r.status = ST_BAD_INDEX;
            end else begin
               for (int k = list_len; k > c.pos; k--)
                  list_mem[k] = list_mem[k - 1];
               list_mem[c.pos] = v;
               list_len++;
            end
         end
         ACT_DELETE_AT: begin
            if (c.pos >= list_len) r.status = ST_BAD_INDEX;
            else drop_entry(c.pos);
         end
         ACT_DELETE_VALUE: begin
            hit = locate_value(v);
            if (hit < 0) r.status = ST_NOT_FOUND;
            else drop_entry(hit);
         end
         ACT_SEARCH: begin
            hit = locate_value(v);
            if (hit < 0) r.status = ST_NOT_FOUND;
            else r.found_index = 5'(hit);
         end
         ACT_DUMP: begin
            // one result per entry, the final one marked last
            for (int k = 0; k < list_len && k < MAX_RESULTS; k++) begin
               r.found_index = 5'(k);
               r.entry_value = 32'(signed'(list_mem[k]));
               r.entry_count = 6'(list_len);
               r.last        = (k + 1 == list_len || k + 1 == MAX_RESULTS);
               awaited_rsp.push_back(r);
            end
         end
         default: ;
      endcase
      if (list_len > peak_len) peak_len = list_len;
      if (!(c.act == ACT_DUMP && list_len > 0)) begin
         r.entry_count = 6'(list_len);
         awaited_rsp.push_back(r);
      end
   endtask

   task automatic flag_field(string what, longint want, longint got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= SHOW_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // driver: present queued items, hold each until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.action     <= '0;
         req_chan.item_value <= '0;
         req_chan.position   <= '0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            apply_list_action(sent_cmd);
            req_pending = 1'b0;
            req_busy = 1'b0;
         end else begin
            req_busy = req_chan.valid;
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               sent_cmd = cmd_backlog.pop_front();
               req_pending = 1'b1;
               req_chan.action     <= sent_cmd.act;
               req_chan.item_value <= sent_cmd.value;
               req_chan.position   <= sent_cmd.pos;
               req_chan.valid      <= 1'b1;
               req_gap = pick_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_checked++;
            status_seen[rsp_chan.status]++;
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOW_LIMIT)
                  $display("%0t: unexpected item, expected none, actual status %0d value %0d",
                           $time, rsp_chan.status, rsp_chan.entry_value);
            end else begin
               flag_field("status", awaited_rsp[0].status, rsp_chan.status);
               flag_field("found_index", awaited_rsp[0].found_index, rsp_chan.found_index);
               flag_field("entry_value", awaited_rsp[0].entry_value, rsp_chan.entry_value);
               flag_field("entry_count", awaited_rsp[0].entry_count, rsp_chan.entry_count);
               flag_field("last", awaited_rsp[0].last, rsp_chan.last);
               void'(awaited_rsp.pop_front());
            end
            rsp_stall = pick_gap();
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_chan.ready <= (rsp_stall == 0);
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic queue_cmd(logic [2:0] act, logic signed [31:0] value, logic [4:0] pos);
      list_cmd_type c;
      while (cmd_backlog.size() != 0) @(posedge clock);
      c.act   = act;
      c.value = value;
      c.pos   = pos;
      cmd_backlog.push_back(c);
   endtask

   task automatic drain_results();
      while (cmd_backlog.size() != 0 || req_pending || awaited_rsp.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 7) - 4;
         5, 6: begin
            if (list_len > 0) return 32'(signed'(list_mem[$urandom_range(0, list_len - 1)]));
            return $urandom_range(0, 7) - 4;
         end
         7: begin
            case ($urandom_range(0, 3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Fill toward full while growing, then empty the list, and repeat.
   task automatic queue_random_cmd();
      int         r;
      logic [2:0] act;
      logic [4:0] pos;
      if (grow && list_len >= CAPACITY && $urandom_range(0, 2) == 0) grow = 0;
      if (!grow && list_len == 0 && $urandom_range(0, 2) == 0) grow = 1;
      r = $urandom_range(0, 99);
      if (grow) begin
         if (r < 45) act = ACT_APPEND;
         else if (r < 75) act = ACT_INSERT_AT;
         else if (r < 83) act = ACT_SEARCH;
         else if (r < 88) act = ACT_DELETE_AT;
         else if (r < 93) act = ACT_DELETE_VALUE;
         else if (r < 97) act = ACT_DUMP;
         else if (r < 99) act = ACT_UNUSED;
         else act = ACT_CLEAR;
      end else begin
         if (r < 30) act = ACT_DELETE_AT;
         else if (r < 55) act = ACT_DELETE_VALUE;
         else if (r < 65) act = ACT_SEARCH;
         else if (r < 73) act = ACT_APPEND;
         else if (r < 81) act = ACT_INSERT_AT;
         else if (r < 91) act = ACT_DUMP;
         else if (r < 94) act = ACT_CLEAR;
         else act = ACT_UNUSED;
      end
      pos = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 3) != 0) begin
         if (act == ACT_INSERT_AT)
            pos = 5'($urandom_range(0, list_len < 31 ? list_len : 31));
         else if (act == ACT_DELETE_AT && list_len > 0)
            pos = 5'($urandom_range(0, list_len - 1));
      end
      queue_cmd(act, pick_value(), pos);
   endtask

   initial begin
      @(negedge reset);
      // empty list corner cases
      queue_cmd(ACT_DUMP,         0,             0);
      queue_cmd(ACT_DELETE_AT,    0,             0);
      queue_cmd(ACT_DELETE_VALUE, 5,             0);
      queue_cmd(ACT_SEARCH,       0,             0);
      queue_cmd(ACT_INSERT_AT,    9,             1);
      // build a list from the value extremes
      queue_cmd(ACT_INSERT_AT,    32'sh7fff_ffff, 0);
      queue_cmd(ACT_APPEND,       32'sh8000_0000, 0);
      queue_cmd(ACT_APPEND,       0,             0);
      queue_cmd(ACT_APPEND,       -1,            0);
      queue_cmd(ACT_INSERT_AT,    123,           4);
      queue_cmd(ACT_INSERT_AT,    55,            1);
      queue_cmd(ACT_SEARCH,       -1,            0);
      queue_cmd(ACT_SEARCH,       99,            0);
      queue_cmd(ACT_APPEND,       -1,            0);
      queue_cmd(ACT_DELETE_VALUE, -1,            0);
      queue_cmd(ACT_DUMP,         0,             0);
      queue_cmd(ACT_DELETE_AT,    0,             31);
      queue_cmd(ACT_DELETE_AT,    0,             6);
      queue_cmd(ACT_DELETE_AT,    0,             0);
      queue_cmd(ACT_DELETE_AT,    0,             4);
      queue_cmd(ACT_UNUSED,       32'h5a5a_a5a5, 21);
      queue_cmd(ACT_DUMP,         0,             0);
      queue_cmd(ACT_CLEAR,        0,             0);
      queue_cmd(ACT_DUMP,         0,             0);
      queue_cmd(ACT_SEARCH,       0,             0);

      // hold the sender until every pending result is back
      drain_results();

      for (int n = 0; n < RANDOM_CMDS; n++) begin
         no_idle = (n >= 40 && n < 70);
         if (n == 75) drain_results();
         queue_random_cmd();
      end
      no_idle = 0;

      drain_results();
      repeat (200) @(posedge clock);

      if (awaited_rsp.size() != 0) begin
         fail_count++;
         $display("%0t: results still awaited, expected 0, actual %0d",
                  $time, awaited_rsp.size());
      end

      $display("Covered %0d actions (append %0d, insert %0d, delete %0d/%0d, search %0d, dump %0d)",
               act_count.sum(), act_count[ACT_APPEND], act_count[ACT_INSERT_AT],
               act_count[ACT_DELETE_AT], act_count[ACT_DELETE_VALUE], act_count[ACT_SEARCH],
               act_count[ACT_DUMP]);
      $display("Checked %0d results: full %0d, bad index %0d, not found %0d, peak length %0d",
               rsp_checked, status_seen[ST_FULL], status_seen[ST_BAD_INDEX],
               status_seen[ST_NOT_FOUND], peak_len);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/oale_pkg.sv
sv/oale_if.sv
sv/oale_mem.sv
sv/oale_seq.sv
sv/ordered_array_list_engine.sv
bench/ordered_array_list_engine_tb.sv
